// ===== rtl/core/q2e_pkg.sv =====
// Shared types, constants and helpers for the quaternion to Euler angle converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package q2e_pkg;
	localparam int CORDIC_STAGES = 16;
	localparam int ISQRT_STEPS   = 31;
	localparam int CW            = 38;
	localparam int ZW            = 34;
	localparam int RW            = 62;
	localparam int AW            = 36;

	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [AW-1:0] HALF_PI_Q13 = 36'sd12868;
	localparam logic signed [AW-1:0] LIM_HEADING = 36'sd51472;
	localparam logic signed [AW-1:0] LIM_ATTITUDE = 36'sd12868;
	localparam logic signed [AW-1:0] LIM_BANK = 36'sd25736;
	localparam logic signed [AW-1:0] RND_HALF = 36'sd65536;
	localparam logic [14:0] THR_RESET = 15'd16351;
	localparam logic ADDR_THR = 1'b0;

	typedef enum logic [1:0] {
		POLE_NONE  = 2'd0,
		POLE_NORTH = 2'd1,
		POLE_SOUTH = 2'd2
	} pole_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_vec_t;

	typedef struct packed {
		logic [RW-1:0] rem;
		logic [RW-1:0] root;
	} sqrt_st_t;

	function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			5'd0:  r = 34'sd843314857;
			5'd1:  r = 34'sd497837829;
			5'd2:  r = 34'sd263043837;
			5'd3:  r = 34'sd133525159;
			5'd4:  r = 34'sd67021687;
			5'd5:  r = 34'sd33543516;
			5'd6:  r = 34'sd16775851;
			5'd7:  r = 34'sd8388437;
			5'd8:  r = 34'sd4194283;
			5'd9:  r = 34'sd2097149;
			5'd10: r = 34'sd1048576;
			5'd11: r = 34'sd524288;
			5'd12: r = 34'sd262144;
			5'd13: r = 34'sd131072;
			5'd14: r = 34'sd65536;
			5'd15: r = 34'sd32768;
			5'd16: r = 34'sd16384;
			5'd17: r = 34'sd8192;
			5'd18: r = 34'sd4096;
			5'd19: r = 34'sd2048;
			5'd20: r = 34'sd1024;
			5'd21: r = 34'sd512;
			5'd22: r = 34'sd256;
			5'd23: r = 34'sd128;
			5'd24: r = 34'sd64;
			5'd25: r = 34'sd32;
			5'd26: r = 34'sd16;
			5'd27: r = 34'sd8;
			5'd28: r = 34'sd4;
			5'd29: r = 34'sd2;
			5'd30: r = 34'sd1;
			default: r = 34'sd0;
		endcase
		return r;
	endfunction

	// quadrant fold so the vectoring loop starts with x >= 0
	function automatic cordic_vec_t prerot(input logic signed [CW-1:0] y,
			input logic signed [CW-1:0] x);
		cordic_vec_t v;
		v.x = x;
		v.y = y;
		v.z = '0;
		if (x < 0) begin
			if (y >= 0) begin
				v.x = y;
				v.y = -x;
				v.z = HALF_PI_Q30;
			end else begin
				v.x = -y;
				v.y = x;
				v.z = -HALF_PI_Q30;
			end
		end
		return v;
	endfunction

	function automatic logic signed [AW-1:0] clamp(input logic signed [AW-1:0] v,
			input logic signed [AW-1:0] lim);
		logic signed [AW-1:0] r;
		r = v;
		if (v > lim) r = lim;
		else if (v < -lim) r = -lim;
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/q2e_isqrt_cell.sv =====
// One digit step of the pipelined integer square root.
// Depends on q2e_pkg.
`timescale 1ns / 1ps
`default_nettype none
module q2e_isqrt_cell import q2e_pkg::*; (
	input  wire logic     clk,
	input  wire logic     en,
	input  wire logic [4:0] step,
	input  wire sqrt_st_t sin,
	output sqrt_st_t      sout
);
	logic [RW-1:0] bitv;
	logic [RW-1:0] trial;
	sqrt_st_t      nxt;

	always_comb begin
		bitv  = RW'(1) << (7'd60 - {1'b0, step, 1'b0});
		trial = sin.root + bitv;
		if (sin.rem >= trial) begin
			nxt.rem  = sin.rem - trial;
			nxt.root = (sin.root >> 1) + bitv;
		end else begin
			nxt.rem  = sin.rem;
			nxt.root = sin.root >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) sout <= nxt;
	end
endmodule
`default_nettype wire

// ===== rtl/core/q2e_cordic_cell.sv =====
// One vectoring micro-rotation of the CORDIC chain.
// Depends on q2e_pkg.
`timescale 1ns / 1ps
`default_nettype none
module q2e_cordic_cell import q2e_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [4:0]  idx,
	input  wire cordic_vec_t vin,
	output cordic_vec_t      vout
);
	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	logic signed [ZW-1:0] ang;
	cordic_vec_t          nxt;

	always_comb begin
		xs  = vin.x >>> idx;
		ys  = vin.y >>> idx;
		ang = atan_q30(idx);
		if (vin.y >= 0) begin
			nxt.x = vin.x + ys;
			nxt.y = vin.y - xs;
			nxt.z = vin.z + ang;
		end else begin
			nxt.x = vin.x - ys;
			nxt.y = vin.y + xs;
			nxt.z = vin.z - ang;
		end
	end

	always_ff @(posedge clk) begin
		if (en) vout <= nxt;
	end
endmodule
`default_nettype wire

// ===== rtl/core/quaternion_to_euler.sv =====
// Quaternion to Euler angle converter, top level.
// Depends on q2e_pkg, q2e_isqrt_cell, q2e_cordic_cell.
//
// channel   | signals                                   | beat
// input     | in_valid, in_ready, quat_x/y/z/w          | one quaternion
// output    | out_valid, out_ready, heading..pole_case  | one angle set
// config    | psel, penable, pwrite, paddr, pwdata...   | one register write
//
// One beat in per cycle while the output register is empty or taken.
// Latency is set by the 31-cell square-root chain and the CORDIC cell chain.
// The whole pipeline advances when the output register is empty or taken.
// Reset clears valid bits and loads pole_threshold with 0.499.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler import q2e_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] quat_x,
	input  wire logic signed [15:0] quat_y,
	input  wire logic signed [15:0] quat_z,
	input  wire logic signed [15:0] quat_w,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [16:0]      heading,
	output logic signed [14:0]      attitude,
	output logic signed [15:0]      bank,
	output logic [1:0]              pole_case,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	logic        en;
	logic [14:0] thr_q;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;
	assign pready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (psel && penable && pwrite && paddr[2] == ADDR_THR) begin
			thr_q <= pwdata[14:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == ADDR_THR && paddr[1:0] == 2'd0) prdata = {17'd0, thr_q};
	end

	// stage 1: products
	logic v_s1;
	logic signed [31:0] xy_s1, zw_s1, yw_s1, xz_s1, yy_s1, zz_s1, xw_s1, yz_s1, xx_s1;
	logic signed [15:0] x_s1, w_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xy_s1 <= quat_x * quat_y;
			zw_s1 <= quat_z * quat_w;
			yw_s1 <= quat_y * quat_w;
			xz_s1 <= quat_x * quat_z;
			yy_s1 <= quat_y * quat_y;
			zz_s1 <= quat_z * quat_z;
			xw_s1 <= quat_x * quat_w;
			yz_s1 <= quat_y * quat_z;
			xx_s1 <= quat_x * quat_x;
			x_s1  <= quat_x;
			w_s1  <= quat_w;
		end
	end

	// stage 2: pole test and CORDIC operands
	logic signed [32:0] test;
	logic signed [32:0] thr_w;
	logic signed [33:0] hn, hd, bn, bd, t2;
	logic signed [31:0] s_c;
	pole_t              pole_c;
	logic signed [CW-1:0] hy_c, hx_c;

	always_comb begin
		test  = 33'(xy_s1) + 33'(zw_s1);
		thr_w = $signed({3'b000, thr_q, 15'd0});
		hn    = (34'(yw_s1) - 34'(xz_s1)) <<< 1;
		hd    = 34'sh40000000 - ((34'(yy_s1) + 34'(zz_s1)) <<< 1);
		bn    = (34'(xw_s1) - 34'(yz_s1)) <<< 1;
		bd    = 34'sh40000000 - ((34'(xx_s1) + 34'(zz_s1)) <<< 1);
		t2    = 34'(test) <<< 1;
		if (t2 > 34'sh40000000) s_c = 32'sh40000000;
		else if (t2 < -34'sh40000000) s_c = -32'sh40000000;
		else s_c = 32'(t2);
		if (test > thr_w) pole_c = POLE_NORTH;
		else if (test < -thr_w) pole_c = POLE_SOUTH;
		else pole_c = POLE_NONE;
		if (pole_c != POLE_NONE) begin
			hy_c = CW'(x_s1) <<< 15;
			hx_c = CW'(w_s1) <<< 15;
		end else begin
			hy_c = CW'(hn);
			hx_c = CW'(hd);
		end
	end

	logic v_s2;
	logic signed [CW-1:0] hy_s2, hx_s2, by_s2, bx_s2;
	logic signed [31:0]   s_s2;
	pole_t                pole_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hy_s2   <= hy_c;
			hx_s2   <= hx_c;
			by_s2   <= CW'(bn);
			bx_s2   <= CW'(bd);
			s_s2    <= s_c;
			pole_s2 <= pole_c;
		end
	end

	// stage 3: s squared
	logic signed [63:0] ssq_c;
	assign ssq_c = s_s2 * s_s2;

	logic v_s3;
	logic [60:0] ssq_s3;
	logic signed [CW-1:0] hy_s3, hx_s3, by_s3, bx_s3;
	logic signed [31:0]   s_s3;
	pole_t                pole_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ssq_s3  <= ssq_c[60:0];
			hy_s3   <= hy_s2;
			hx_s3   <= hx_s2;
			by_s3   <= by_s2;
			bx_s3   <= bx_s2;
			s_s3    <= s_s2;
			pole_s3 <= pole_s2;
		end
	end

	// square root chain with side data delayed alongside
	sqrt_st_t sq_in;
	sqrt_st_t sq [ISQRT_STEPS];
	logic                 sv_q    [ISQRT_STEPS];
	logic signed [CW-1:0] shy_q   [ISQRT_STEPS];
	logic signed [CW-1:0] shx_q   [ISQRT_STEPS];
	logic signed [CW-1:0] sby_q   [ISQRT_STEPS];
	logic signed [CW-1:0] sbx_q   [ISQRT_STEPS];
	logic signed [31:0]   ss_q    [ISQRT_STEPS];
	pole_t                spole_q [ISQRT_STEPS];

	always_comb begin
		sq_in.rem  = RW'((61'd1 << 60) - ssq_s3);
		sq_in.root = '0;
	end

	for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_sqrt
		q2e_isqrt_cell u_cell (
			.clk (clk),
			.en  (en),
			.step(5'(k)),
			.sin (k == 0 ? sq_in : sq[k == 0 ? 0 : k-1]),
			.sout(sq[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ISQRT_STEPS; k++) sv_q[k] <= 1'b0;
		end else if (en) begin
			sv_q[0] <= v_s3;
			for (int k = 1; k < ISQRT_STEPS; k++) sv_q[k] <= sv_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			shy_q[0]   <= hy_s3;
			shx_q[0]   <= hx_s3;
			sby_q[0]   <= by_s3;
			sbx_q[0]   <= bx_s3;
			ss_q[0]    <= s_s3;
			spole_q[0] <= pole_s3;
			for (int k = 1; k < ISQRT_STEPS; k++) begin
				shy_q[k]   <= shy_q[k-1];
				shx_q[k]   <= shx_q[k-1];
				sby_q[k]   <= sby_q[k-1];
				sbx_q[k]   <= sbx_q[k-1];
				ss_q[k]    <= ss_q[k-1];
				spole_q[k] <= spole_q[k-1];
			end
		end
	end

	// three CORDIC chains
	cordic_vec_t h_in, a_in, b_in;
	cordic_vec_t hc [CORDIC_STAGES];
	cordic_vec_t ac [CORDIC_STAGES];
	cordic_vec_t bc [CORDIC_STAGES];
	logic        cv_q    [CORDIC_STAGES];
	pole_t       cpole_q [CORDIC_STAGES];

	always_comb begin
		h_in = prerot(shy_q[ISQRT_STEPS-1], shx_q[ISQRT_STEPS-1]);
		b_in = prerot(sby_q[ISQRT_STEPS-1], sbx_q[ISQRT_STEPS-1]);
		a_in = prerot(CW'(ss_q[ISQRT_STEPS-1]),
			$signed({{(CW-31){1'b0}}, sq[ISQRT_STEPS-1].root[30:0]}));
	end

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
		q2e_cordic_cell u_h (
			.clk (clk),
			.en  (en),
			.idx (5'(k)),
			.vin (k == 0 ? h_in : hc[k == 0 ? 0 : k-1]),
			.vout(hc[k])
		);
		q2e_cordic_cell u_a (
			.clk (clk),
			.en  (en),
			.idx (5'(k)),
			.vin (k == 0 ? a_in : ac[k == 0 ? 0 : k-1]),
			.vout(ac[k])
		);
		q2e_cordic_cell u_b (
			.clk (clk),
			.en  (en),
			.idx (5'(k)),
			.vin (k == 0 ? b_in : bc[k == 0 ? 0 : k-1]),
			.vout(bc[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CORDIC_STAGES; k++) cv_q[k] <= 1'b0;
		end else if (en) begin
			cv_q[0] <= sv_q[ISQRT_STEPS-1];
			for (int k = 1; k < CORDIC_STAGES; k++) cv_q[k] <= cv_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cpole_q[0] <= spole_q[ISQRT_STEPS-1];
			for (int k = 1; k < CORDIC_STAGES; k++) cpole_q[k] <= cpole_q[k-1];
		end
	end

	// rounding, pole selection, clamp
	pole_t               fpole;
	logic signed [AW-1:0] hz, az, bz, h_r, a_r, b_r;

	always_comb begin
		fpole = cpole_q[CORDIC_STAGES-1];
		hz    = AW'(hc[CORDIC_STAGES-1].z);
		az    = AW'(ac[CORDIC_STAGES-1].z);
		bz    = AW'(bc[CORDIC_STAGES-1].z);
		if (fpole != POLE_NONE) begin
			h_r = ((hz <<< 1) + RND_HALF) >>> 17;
			if (fpole == POLE_SOUTH) h_r = -h_r;
			a_r = (fpole == POLE_NORTH) ? HALF_PI_Q13 : -HALF_PI_Q13;
			b_r = '0;
		end else begin
			h_r = (hz + RND_HALF) >>> 17;
			a_r = (az + RND_HALF) >>> 17;
			b_r = (bz + RND_HALF) >>> 17;
		end
		h_r = clamp(h_r, LIM_HEADING);
		a_r = clamp(a_r, LIM_ATTITUDE);
		b_r = clamp(b_r, LIM_BANK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= cv_q[CORDIC_STAGES-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			heading   <= h_r[16:0];
			attitude  <= a_r[14:0];
			bank      <= b_r[15:0];
			pole_case <= fpole;
		end
	end
endmodule
`default_nettype wire
